>>> design/asrf_pkg.sv
// Shared types, constants and helper functions for the alphabet sequence run finder.
// Used by asrf_front, asrf_queue, asrf_back and the top level; depends on nothing.
package asrf_pkg;

    localparam int MAX_TEXT_LEN = 256;
    localparam int POS_LIMIT    = (MAX_TEXT_LEN > 256) ? 256 : MAX_TEXT_LEN;
    localparam logic [7:0] POS_LAST = 8'(POS_LIMIT - 1);

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 2;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [1:0] ALPHA_LOWER = 2'd0;
    localparam logic [1:0] ALPHA_UPPER = 2'd1;
    localparam logic [1:0] ALPHA_DIGIT = 2'd2;
    localparam logic [1:0] ALPHA_NONE  = 2'd3;

    localparam logic [15:0] CU_LOWER_FIRST = 16'h0061;
    localparam logic [15:0] CU_LOWER_LAST  = 16'h007A;
    localparam logic [15:0] CU_UPPER_FIRST = 16'h0041;
    localparam logic [15:0] CU_UPPER_LAST  = 16'h005A;
    localparam logic [15:0] CU_DIGIT_FIRST = 16'h0030;
    localparam logic [15:0] CU_DIGIT_LAST  = 16'h0039;

    localparam logic [4:0] SIZE_LETTERS = 5'd26;
    localparam logic [4:0] SIZE_DIGITS  = 5'd10;

    typedef struct packed {
        logic [7:0] run_start;
        logic [7:0] run_end;
        logic [1:0] alpha;
        logic       asc;
    } t_result;

    typedef struct packed {
        t_result first;
        t_result second;
        logic    two;
        logic    ovf;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [4:0] alpha_size(input logic [1:0] alpha);
        logic [4:0] s;
        s = (alpha == ALPHA_DIGIT) ? SIZE_DIGITS : SIZE_LETTERS;
        return s;
    endfunction

endpackage

>>> design/alphabet_sequence_run_finder.sv
// Top level of the alphabet sequence run finder: front end, bundle queue and output stage.
// Depends on asrf_pkg, asrf_front, asrf_queue and asrf_back.
//
// Input channel s_axis: one 16-bit code unit per word, tlast on the last unit of a text.
// Output channel m_axis: one word per finished run of two or more characters in the
// lower case, upper case or digit alphabet, ascending or descending, with wrap-around.
// A run is reported when it breaks or when the text ends; tlast marks the final
// word caused by one input word, and input words that close no run cause none.
// Positions saturate at 255; later units of the same text only set the overflow flag.
// Throughput: one input word per cycle while the bundle queue is not full. A result
// word passes the bundle queue and the output register; an input word that closes
// two runs yields two output words. The four-entry bundle queue absorbs such bursts.
// When the receiver stalls the output word holds and the queue fills; s_axis_tready
// drops only once four bundles are waiting.
// Synchronous active-low reset empties the queue and the output stage and starts a
// new text at position 0.
module alphabet_sequence_run_finder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [asrf_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] code_unit
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] run_start, [15:8] run_end, [20:16] alphabet_size, [21] ascending,
    // [22] length_overflow, [23] zero
    output logic [asrf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic [asrf_pkg::OUT_USER_W-1:0] m_axis_tuser,   // [1:0] alphabet_id
    output logic                            m_axis_tlast
);
    import asrf_pkg::*;

    logic    push;
    logic    pop;
    t_bundle push_data;
    t_bundle pop_data;
    t_q_stat q_stat;

    asrf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_code   (s_axis_tdata),
        .i_eot    (s_axis_tlast),
        .i_q      (q_stat),
        .o_push   (push),
        .o_bundle (push_data)
    );

    asrf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (pop_data),
        .o_stat  (q_stat)
    );

    asrf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (pop_data),
        .i_q     (q_stat),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_user  (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

endmodule

>>> design/asrf_front.sv
// Front end: classifies each code unit, tracks the open runs and builds the result bundle.
// Depends on asrf_pkg; feeds asrf_queue.
module asrf_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [15:0]            i_code,
    input  logic                   i_eot,
    input  asrf_pkg::t_q_stat      i_q,
    output logic                   o_push,
    output asrf_pkg::t_bundle      o_bundle
);
    import asrf_pkg::*;

    logic [7:0] r_pos, n_pos;
    logic [1:0] r_prev_alpha, n_prev_alpha;
    logic [4:0] r_prev_idx, n_prev_idx;
    logic [7:0] r_up_start, n_up_start;
    logic [7:0] r_dn_start, n_dn_start;
    logic       r_ovf, n_ovf;
    logic       r_full, n_full;

    logic       accept;
    logic [1:0] cls;
    logic [4:0] idx;
    logic [4:0] size_n;
    logic [5:0] sum_up;
    logic [4:0] nx;
    logic [4:0] pv;
    logic       have_prev;
    logic       up_cont;
    logic       dn_cont;
    logic [7:0] pos_m1;
    logic [1:0] eot_alpha;
    logic [7:0] eot_up_start;
    logic [7:0] eot_dn_start;
    t_result    cand [4];
    logic [3:0] cval;
    logic [2:0] cnt;
    t_bundle    bundle;

    assign o_ready = ~i_q.full;
    assign accept  = i_valid & o_ready;

    always_comb begin
        cls = ALPHA_NONE;
        idx = 5'd0;
        if (i_code >= CU_LOWER_FIRST && i_code <= CU_LOWER_LAST) begin
            cls = ALPHA_LOWER;
            idx = 5'(i_code - CU_LOWER_FIRST);
        end else if (i_code >= CU_UPPER_FIRST && i_code <= CU_UPPER_LAST) begin
            cls = ALPHA_UPPER;
            idx = 5'(i_code - CU_UPPER_FIRST);
        end else if (i_code >= CU_DIGIT_FIRST && i_code <= CU_DIGIT_LAST) begin
            cls = ALPHA_DIGIT;
            idx = 5'(i_code - CU_DIGIT_FIRST);
        end
    end

    always_comb begin
        size_n    = alpha_size(r_prev_alpha);
        sum_up    = {1'b0, r_prev_idx} + 6'd1;
        nx        = (sum_up >= {1'b0, size_n}) ? 5'd0 : sum_up[4:0];
        pv        = (r_prev_idx == 5'd0 || r_prev_idx >= size_n) ? size_n - 5'd1
                                                                 : r_prev_idx - 5'd1;
        have_prev = (r_prev_alpha != ALPHA_NONE);
        up_cont   = have_prev && (cls == r_prev_alpha) && (idx == nx);
        dn_cont   = have_prev && (cls == r_prev_alpha) && (idx == pv);
        pos_m1    = r_pos - 8'd1;

        eot_alpha    = r_full ? r_prev_alpha : cls;
        eot_up_start = (r_full || up_cont) ? r_up_start : r_pos;
        eot_dn_start = (r_full || dn_cont) ? r_dn_start : r_pos;

        cand[0] = '{run_start: r_up_start, run_end: pos_m1, alpha: r_prev_alpha, asc: 1'b1};
        cand[1] = '{run_start: r_dn_start, run_end: pos_m1, alpha: r_prev_alpha, asc: 1'b0};
        cand[2] = '{run_start: eot_up_start, run_end: r_pos, alpha: eot_alpha, asc: 1'b1};
        cand[3] = '{run_start: eot_dn_start, run_end: r_pos, alpha: eot_alpha, asc: 1'b0};

        cval[0] = ~r_full && have_prev && ~up_cont && (r_pos != 8'd0) && (r_up_start < pos_m1);
        cval[1] = ~r_full && have_prev && ~dn_cont && (r_pos != 8'd0) && (r_dn_start < pos_m1);
        cval[2] = i_eot && (eot_alpha != ALPHA_NONE) && (eot_up_start < r_pos);
        cval[3] = i_eot && (eot_alpha != ALPHA_NONE) && (eot_dn_start < r_pos);
    end

    // take the first two candidates in report order
    always_comb begin
        bundle     = '0;
        cnt        = 3'd0;
        bundle.ovf = r_ovf | r_full;
        for (int i = 0; i < 4; i++) begin
            if (cval[i]) begin
                if (cnt == 3'd0) begin
                    bundle.first = cand[i];
                end else if (cnt == 3'd1) begin
                    bundle.second = cand[i];
                    bundle.two    = 1'b1;
                end
                cnt = cnt + 3'd1;
            end
        end
    end

    assign o_push   = accept && (cval != 4'd0);
    assign o_bundle = bundle;

    always_comb begin
        n_pos        = r_pos;
        n_prev_alpha = r_prev_alpha;
        n_prev_idx   = r_prev_idx;
        n_up_start   = r_up_start;
        n_dn_start   = r_dn_start;
        n_ovf        = r_ovf;
        n_full       = r_full;
        if (accept) begin
            if (i_eot) begin
                n_pos        = 8'd0;
                n_prev_alpha = ALPHA_NONE;
                n_prev_idx   = 5'd0;
                n_up_start   = 8'd0;
                n_dn_start   = 8'd0;
                n_ovf        = 1'b0;
                n_full       = 1'b0;
            end else if (r_full) begin
                n_ovf = 1'b1;
            end else begin
                n_up_start   = up_cont ? r_up_start : r_pos;
                n_dn_start   = dn_cont ? r_dn_start : r_pos;
                n_prev_alpha = cls;
                n_prev_idx   = idx;
                if (r_pos == POS_LAST) begin
                    n_full = 1'b1;
                end else begin
                    n_pos = r_pos + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= 8'd0;
            r_prev_alpha <= ALPHA_NONE;
            r_prev_idx   <= 5'd0;
            r_up_start   <= 8'd0;
            r_dn_start   <= 8'd0;
            r_ovf        <= 1'b0;
            r_full       <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_prev_alpha <= n_prev_alpha;
            r_prev_idx   <= n_prev_idx;
            r_up_start   <= n_up_start;
            r_dn_start   <= n_dn_start;
            r_ovf        <= n_ovf;
            r_full       <= n_full;
        end
    end

endmodule

>>> design/asrf_queue.sv
// Short queue of result bundles between the front end and the output stage.
// Depends on asrf_pkg.
module asrf_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  asrf_pkg::t_bundle      i_data,
    input  logic                   i_pop,
    output asrf_pkg::t_bundle      o_data,
    output asrf_pkg::t_q_stat      o_stat
);
    import asrf_pkg::*;

    t_bundle             r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr, n_wr;
    logic [QPTR_W-1:0]   r_rd, n_rd;
    logic [QCNT_W-1:0]   r_cnt, n_cnt;

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> design/asrf_back.sv
// Output stage: unpacks each queued bundle into one or two output words.
// Depends on asrf_pkg; reads from asrf_queue.
module asrf_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  asrf_pkg::t_bundle           i_data,
    input  asrf_pkg::t_q_stat           i_q,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [asrf_pkg::OUT_DATA_W-1:0] o_data,
    output logic [asrf_pkg::OUT_USER_W-1:0] o_user,
    output logic                        o_last
);
    import asrf_pkg::*;

    t_bundle r_b;
    logic    r_valid;
    logic    r_idx;
    t_result word;
    logic    last;
    logic    hs;
    logic    load;

    always_comb begin
        word = r_idx ? r_b.second : r_b.first;
        last = r_idx | ~r_b.two;
        hs   = r_valid & i_ready;
        load = ~r_valid | (hs & last);
    end

    assign o_pop   = load & ~i_q.empty;
    assign o_valid = r_valid;
    assign o_last  = last;
    assign o_user  = word.alpha;
    assign o_data  = {1'b0, r_b.ovf, word.asc, alpha_size(word.alpha),
                      word.run_end, word.run_start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else if (load) begin
            r_valid <= ~i_q.empty;
            r_idx   <= 1'b0;
        end else if (hs) begin
            r_idx <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b <= i_data;
        end
    end

endmodule

>>> design/asrf_checker.sv
// Port-level checks for the alphabet sequence run finder, bound to the top level.
// Depends on asrf_pkg and alphabet_sequence_run_finder.
module asrf_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [asrf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [asrf_pkg::OUT_USER_W-1:0] m_axis_tuser,
    input logic                            m_axis_tlast
);
    import asrf_pkg::*;

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // size field follows the alphabet
    a_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[20:16] == alpha_size(m_axis_tuser))
        else $error("alphabet size does not match alphabet id");

    // a reported run spans at least two positions
    a_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:0] < m_axis_tdata[15:8])
        else $error("run start not below run end");

    // a non-final word is followed by its partner at once
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && m_axis_tlast)
        else $error("second word of a pair missing");

endmodule

bind alphabet_sequence_run_finder asrf_checker u_asrf_checker (.*);

>>> tb/run_report_checker.sv
// Checker for the alphabet sequence run finder: predicts the run words from the input
// stream and compares them with the output stream. Depends on asrf_pkg.
module run_report_checker
    import asrf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [IN_DATA_W-1:0]  i_in_data,   // [15:0] code_unit
    input  logic                  i_in_last,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    // [7:0] run_start, [15:8] run_end, [20:16] alphabet_size, [21] ascending,
    // [22] length_overflow, [23] zero
    input  logic [OUT_DATA_W-1:0] i_out_data,
    input  logic [OUT_USER_W-1:0] i_out_user,  // [1:0] alphabet_id
    input  logic                  i_out_last,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_runs
);

    typedef struct packed {
        logic [7:0] run_start;
        logic [7:0] run_end;
        logic [1:0] alpha;
        logic [4:0] alpha_size;
        logic       asc;
        logic       ovf;
        logic       last;
    } t_run_word;

    t_run_word  expected_runs[$];
    int         step_count;

    logic [7:0] next_pos;
    logic [1:0] prev_alpha;
    logic [4:0] prev_sym;
    logic [7:0] up_start;
    logic [7:0] down_start;
    logic       ovf_seen;
    logic       text_full;

    task automatic clear_text();
        next_pos   = 8'd0;
        prev_alpha = ALPHA_NONE;
        prev_sym   = 5'd0;
        up_start   = 8'd0;
        down_start = 8'd0;
        ovf_seen   = 1'b0;
        text_full  = 1'b0;
    endtask

    task automatic stage_run(input logic [7:0] first_pos, input logic [7:0] last_pos,
                             input logic [1:0] alpha, input logic asc);
        t_run_word w;
        if (step_count < 2) begin
            w.run_start  = first_pos;
            w.run_end    = last_pos;
            w.alpha      = alpha;
            w.alpha_size = (alpha == ALPHA_DIGIT) ? SIZE_DIGITS : SIZE_LETTERS;
            w.asc        = asc;
            w.ovf        = ovf_seen;
            w.last       = 1'b0;
            expected_runs.push_back(w);
            step_count++;
        end
    endtask

    task automatic predict_runs(input logic [15:0] cu, input logic eot);
        int         p;
        int         last_pos;
        int         sz;
        int         nx;
        int         pv;
        logic [1:0] cls;
        logic [4:0] sym;
        logic       up_cont;
        logic       down_cont;
        t_run_word  w;
        step_count = 0;
        up_cont    = 1'b0;
        down_cont  = 1'b0;
        if (!text_full) begin
            p   = int'(next_pos);
            cls = ALPHA_NONE;
            sym = 5'd0;
            if (cu >= CU_LOWER_FIRST && cu <= CU_LOWER_LAST) begin
                cls = ALPHA_LOWER;
                sym = 5'(cu - CU_LOWER_FIRST);
            end else if (cu >= CU_UPPER_FIRST && cu <= CU_UPPER_LAST) begin
                cls = ALPHA_UPPER;
                sym = 5'(cu - CU_UPPER_FIRST);
            end else if (cu >= CU_DIGIT_FIRST && cu <= CU_DIGIT_LAST) begin
                cls = ALPHA_DIGIT;
                sym = 5'(cu - CU_DIGIT_FIRST);
            end
            if (prev_alpha != ALPHA_NONE) begin
                sz = (prev_alpha == ALPHA_DIGIT) ? 10 : 26;
                nx = (int'(prev_sym) + 1 >= sz) ? 0 : int'(prev_sym) + 1;
                pv = (prev_sym == 5'd0 || int'(prev_sym) >= sz) ? sz - 1 : int'(prev_sym) - 1;
                if (cls == prev_alpha) begin
                    up_cont   = (int'(sym) == nx);
                    down_cont = (int'(sym) == pv);
                end
                if (!up_cont && p >= 1 && int'(up_start) < p - 1)
                    stage_run(up_start, 8'(p - 1), prev_alpha, 1'b1);
                if (!down_cont && p >= 1 && int'(down_start) < p - 1)
                    stage_run(down_start, 8'(p - 1), prev_alpha, 1'b0);
            end
            if (!up_cont)
                up_start = 8'(p);
            if (!down_cont)
                down_start = 8'(p);
            prev_alpha = cls;
            prev_sym   = sym;
            last_pos   = p;
            if (p + 1 >= POS_LIMIT)
                text_full = 1'b1;
            else
                next_pos = 8'(p + 1);
        end else begin
            ovf_seen = 1'b1;
            last_pos = int'(next_pos);
        end
        if (eot) begin
            if (prev_alpha != ALPHA_NONE) begin
                if (int'(up_start) < last_pos)
                    stage_run(up_start, 8'(last_pos), prev_alpha, 1'b1);
                if (int'(down_start) < last_pos)
                    stage_run(down_start, 8'(last_pos), prev_alpha, 1'b0);
            end
            clear_text();
        end
        if (step_count > 0) begin
            w = expected_runs.pop_back();
            w.last = 1'b1;
            expected_runs.push_back(w);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_run_word got;
        t_run_word want;
        if (!i_rst_n) begin
            clear_text();
            expected_runs.delete();
            o_errors  = 0;
            o_pending = 0;
            o_runs    = 0;
        end else begin
            if (i_in_valid && i_in_ready)
                predict_runs(i_in_data, i_in_last);
            if (i_out_valid && i_out_ready) begin
                got.run_start  = i_out_data[7:0];
                got.run_end    = i_out_data[15:8];
                got.alpha_size = i_out_data[20:16];
                got.asc        = i_out_data[21];
                got.ovf        = i_out_data[22];
                got.alpha      = i_out_user;
                got.last       = i_out_last;
                o_runs = o_runs + 1;
                if (expected_runs.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected run word %0d: start %0d end %0d alphabet %0d",
                                 o_runs, got.run_start, got.run_end, got.alpha);
                    o_errors = o_errors + 1;
                end else begin
                    want = expected_runs.pop_front();
                    if (got !== want || i_out_data[23] !== 1'b0) begin
                        if (o_errors < 10) begin
                            $display("run word %0d mismatch (pad bit %b)", o_runs,
                                     i_out_data[23]);
                            $display({"  expected start %0d end %0d alphabet %0d",
                                      " size %0d asc %b ovf %b last %b"},
                                     want.run_start, want.run_end, want.alpha,
                                     want.alpha_size, want.asc, want.ovf, want.last);
                            $display({"  actual   start %0d end %0d alphabet %0d",
                                      " size %0d asc %b ovf %b last %b"},
                                     got.run_start, got.run_end, got.alpha,
                                     got.alpha_size, got.asc, got.ovf, got.last);
                        end
                        o_errors = o_errors + 1;
                    end
                end
            end
            o_pending = expected_runs.size();
        end
    end

endmodule

>>> tb/tb.sv
// Top of the run finder testbench: clock, reset, text stimulus with bursts and gaps,
// receiver stalls and the verdict. Depends on asrf_pkg, run_report_checker and the block.
module tb;
    import asrf_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    typedef enum int {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_PERIODIC} t_rdy_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // [15:0] code_unit
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [7:0] run_start, [15:8] run_end, [20:16] alphabet_size, [21] ascending,
    // [22] length_overflow, [23] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;   // [1:0] alphabet_id
    logic                  m_axis_tlast;

    int          n_errors;
    int          n_pending;
    int          n_runs;
    int          n_words;
    int          n_texts;
    int          n_overflow_texts;
    int          burst_left;
    int unsigned cycle_cnt = 0;
    t_rdy_mode   rdy_mode  = RDY_ALWAYS;
    int          rdy_left  = 0;

    alphabet_sequence_run_finder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    run_report_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_last   (s_axis_tlast),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_user  (m_axis_tuser),
        .i_out_last  (m_axis_tlast),
        .o_errors    (n_errors),
        .o_pending   (n_pending),
        .o_runs      (n_runs)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (rdy_left == 0) begin
            rdy_mode <= t_rdy_mode'($urandom_range(0, 3));
            rdy_left <= $urandom_range(20, 200);
        end else begin
            rdy_left <= rdy_left - 1;
        end
        case (rdy_mode)
            RDY_ALWAYS:   m_axis_tready <= 1'b1;
            RDY_HALF:     m_axis_tready <= 1'($urandom_range(0, 1));
            RDY_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
            RDY_PERIODIC: m_axis_tready <= (cycle_cnt % 5 != 0);
            default:      m_axis_tready <= 1'b1;
        endcase
    end

    function automatic logic [15:0] code_of(input logic [1:0] alpha, input int sym);
        case (alpha)
            ALPHA_LOWER: code_of = CU_LOWER_FIRST + 16'(sym);
            ALPHA_UPPER: code_of = CU_UPPER_FIRST + 16'(sym);
            default:     code_of = CU_DIGIT_FIRST + 16'(sym);
        endcase
    endfunction

    task automatic send_word(input logic [15:0] cu, input logic eot);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cu;
        s_axis_tlast  <= eot;
        @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
        n_words++;
        if (eot)
            n_texts++;
    endtask

    task automatic send_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_word({8'h00, s[i]}, i == s.len() - 1);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(negedge i_clk);
        while (n_pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic send_text(input int len);
        int         k;
        int         j;
        int         seg;
        int         sz;
        int         sym;
        int         kind;
        logic [1:0] alpha;
        logic       up;
        logic [15:0] cu;
        k     = 0;
        alpha = ALPHA_LOWER;
        sym   = 0;
        up    = 1'b1;
        sz    = 26;
        while (k < len) begin
            kind = $urandom_range(0, 99);
            if (kind < 72) begin
                if (k == 0 || kind >= 40) begin
                    alpha = 2'($urandom_range(0, 2));
                    sz    = (alpha == ALPHA_DIGIT) ? 10 : 26;
                    sym   = $urandom_range(0, sz - 1);
                    up    = 1'($urandom_range(0, 1));
                end else begin
                    // turn around within the same alphabet
                    up  = !up;
                    sym = up ? (sym + 1) % sz : (sym + sz - 1) % sz;
                end
                seg = $urandom_range(1, 14);
                for (j = 0; j < seg && k < len; j++) begin
                    send_word(code_of(alpha, sym), k == len - 1);
                    k++;
                    if (j < seg - 1)
                        sym = up ? (sym + 1) % sz : (sym + sz - 1) % sz;
                end
            end else begin
                if (kind < 82) begin
                    cu = 16'($urandom_range(0, 65535));
                end else if (kind < 92) begin
                    case ($urandom_range(0, 7))
                        0:       cu = 16'h002F;
                        1:       cu = 16'h003A;
                        2:       cu = 16'h0040;
                        3:       cu = 16'h005B;
                        4:       cu = 16'h0060;
                        5:       cu = 16'h007B;
                        6:       cu = 16'h0000;
                        default: cu = 16'hFFFF;
                    endcase
                end else if (kind < 96) begin
                    cu = code_of(alpha, sym);
                    cu = {8'($urandom_range(1, 255)), cu[7:0]};
                end else begin
                    cu = code_of(alpha, sym);
                end
                send_word(cu, k == len - 1);
                k++;
            end
        end
    endtask

    initial begin
        int len;
        int text_no;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        burst_left    = 0;
        n_words       = 0;
        n_texts       = 0;
        n_overflow_texts = 0;
        text_no       = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wrap-around runs, single character text, noise breaks, two runs in one word
        send_str("zab");
        send_str("09Z");
        send_str("q");
        send_word(code_of(ALPHA_UPPER, 23), 1'b0);
        send_word(code_of(ALPHA_UPPER, 24), 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(code_of(ALPHA_UPPER, 24), 1'b0);
        send_word(code_of(ALPHA_UPPER, 23), 1'b0);
        send_word(16'h0000, 1'b1);
        send_str("abcb");
        send_str("/01:");
        send_str("@AB[");
        wait_drained();

        while (n_words < 700) begin
            if (text_no == 3)
                len = POS_LIMIT;
            else if (text_no == 6)
                len = POS_LIMIT + $urandom_range(1, 40);
            else
                len = $urandom_range(1, 40);
            send_text(len);
            text_no++;
            if (len > POS_LIMIT)
                n_overflow_texts++;
            if (len >= POS_LIMIT || $urandom_range(0, 19) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("sent %0d words in %0d texts, %0d of them past the position limit",
                 n_words, n_texts, n_overflow_texts);
        $display("checked %0d run words, %0d still outstanding", n_runs, n_pending);
        if (n_errors == 0 && n_pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
